// ===== design/sdfs_pkg.sv =====
// Shared types and constants of the sphere distance field splat block.
package sdfs_pkg;

  localparam int GRID_DIM_DEFAULT = 64;
  localparam int MARGIN_DEFAULT   = 2;

  localparam int OP_W     = 2;
  localparam int CENTER_W = 14;
  localparam int RADIUS_W = 12;
  localparam int ID_W     = 16;
  localparam int IDX_W    = 18;
  localparam int DIST_W   = 19;
  localparam int OWNER_W  = 16;
  localparam int MEM_W    = DIST_W + OWNER_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int QDEPTH   = 2;

  localparam logic signed [DIST_W-1:0]  FAR_VALUE  = 19'sd262143;
  localparam logic signed [OWNER_W-1:0] OWNER_NONE = -16'sd1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_SPLAT = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BOX,
    ST_SQX,
    ST_SQY,
    ST_SQZ,
    ST_SUM,
    ST_ROOT,
    ST_CMP,
    ST_RT1,
    ST_RT2,
    ST_ROUT
  } bst_e;

  typedef struct packed {
    op_e                       op;
    logic [CENTER_W-1:0]       cx;
    logic [CENTER_W-1:0]       cy;
    logic [CENTER_W-1:0]       cz;
    logic [RADIUS_W-1:0]       rad;
    logic signed [ID_W-1:0]    id;
    logic [IDX_W-1:0]          idx;
  } item_t;

  typedef struct packed {
    logic init_busy;
  } stat_t;

endpackage

// ===== design/sdfs_front.sv =====
// Front end: takes input beats, drops unused opcodes and packs items for the queue.
module sdfs_front (
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [sdfs_pkg::OP_W-1:0]             opcode_i,
  input  logic [sdfs_pkg::CENTER_W-1:0]         center_x_i,
  input  logic [sdfs_pkg::CENTER_W-1:0]         center_y_i,
  input  logic [sdfs_pkg::CENTER_W-1:0]         center_z_i,
  input  logic [sdfs_pkg::RADIUS_W-1:0]         sphere_radius_i,
  input  logic signed [sdfs_pkg::ID_W-1:0]      sphere_id_i,
  input  logic [sdfs_pkg::IDX_W-1:0]            cell_index_i,
  input  sdfs_pkg::stat_t                       stat_i,
  input  logic                                  full_i,
  output logic                                  push_o,
  output sdfs_pkg::item_t                       item_o
);

  logic known;

  always_comb begin
    case (sdfs_pkg::op_e'(opcode_i))
      sdfs_pkg::OP_CLEAR, sdfs_pkg::OP_SPLAT, sdfs_pkg::OP_READ: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign in_ready_o = !full_i && !stat_i.init_busy;
  assign push_o     = in_valid_i && in_ready_o && known;

  always_comb begin
    item_o.op  = sdfs_pkg::op_e'(opcode_i);
    item_o.cx  = center_x_i;
    item_o.cy  = center_y_i;
    item_o.cz  = center_z_i;
    item_o.rad = sphere_radius_i;
    item_o.id  = sphere_id_i;
    item_o.idx = cell_index_i;
  end

endmodule

// ===== design/sdfs_fifo.sv =====
// Short item queue between the front end and the engine.
module sdfs_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sdfs_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output sdfs_pkg::item_t item_o
);

  localparam int PW = (sdfs_pkg::QDEPTH > 1) ? $clog2(sdfs_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(sdfs_pkg::QDEPTH + 1);

  sdfs_pkg::item_t slot_q [sdfs_pkg::QDEPTH];
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(sdfs_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = (wp_q == PW'(sdfs_pkg::QDEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (pop_i) begin
      rp_d = (rp_q == PW'(sdfs_pkg::QDEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= item_i;
    end
  end

endmodule

// ===== design/sdfs_back.sv =====
// Engine: grid store, clear sweep, splat walk with iterative square root, and cell reads.
module sdfs_back #(
  parameter int GRID_DIM     = sdfs_pkg::GRID_DIM_DEFAULT,
  parameter int MARGIN_CELLS = sdfs_pkg::MARGIN_DEFAULT
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [sdfs_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [sdfs_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   q_valid_i,
  input  sdfs_pkg::item_t                        q_item_i,
  output logic                                   q_pop_o,
  output sdfs_pkg::stat_t                        stat_o,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [sdfs_pkg::DIST_W-1:0]     cell_distance_o,
  output logic signed [sdfs_pkg::OWNER_W-1:0]    cell_owner_o
);

  localparam int CW    = $clog2(GRID_DIM);
  localparam int SZW   = $clog2(GRID_DIM + 1);
  localparam int AW    = 3 * CW;
  localparam int STORE_CELLS = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int DW0   = (CW + 8 > sdfs_pkg::CENTER_W) ? CW + 8 : sdfs_pkg::CENTER_W;
  localparam int DW    = DW0 + 1;
  localparam int SQW   = 2 * DW;
  localparam int SUMW  = SQW + 2;
  localparam int NSTEP = (SUMW + 1) / 2;
  localparam int RMW   = 2 * NSTEP;
  localparam int VW    = RMW + 3;
  localparam int SCW   = $clog2(NSTEP + 1);
  localparam int TQW   = CW + SZW + 1;
  localparam int ADW   = TQW + SZW;
  localparam int TW    = 3 * SZW;
  localparam int IXW   = sdfs_pkg::IDX_W + AW + 1;
  localparam int ITW   = sdfs_pkg::IDX_W + TW;
  localparam int SIZE_RST = (GRID_DIM < 64) ? GRID_DIM : 64;
  localparam int OW    = sdfs_pkg::OWNER_W;
  localparam int MW    = sdfs_pkg::MEM_W;

  typedef struct packed {
    logic [CW-1:0] lo;
    logic [CW-1:0] hi;
    logic          empty;
  } box_t;

  function automatic box_t box_of(input logic [sdfs_pkg::CENTER_W-1:0] c,
                                  input logic [sdfs_pkg::RADIUS_W-1:0] rad,
                                  input logic [SZW-1:0] n);
    logic signed [15:0] reach;
    logic signed [15:0] lo_s;
    logic signed [15:0] hi_s;
    logic signed [15:0] nm1;
    box_t b;
    reach = $signed(16'(rad) + 16'(MARGIN_CELLS * 256));
    lo_s  = ($signed(16'(c)) - reach) >>> 8;
    hi_s  = ($signed(16'(c)) + reach + 16'sd255) >>> 8;
    nm1   = $signed(16'(n)) - 16'sd1;
    if (lo_s < 16'sd0) lo_s = 16'sd0;
    if (hi_s > nm1) hi_s = nm1;
    b.empty = (lo_s > hi_s);
    b.lo    = CW'(lo_s);
    b.hi    = CW'(hi_s);
    return b;
  endfunction

  function automatic logic [SZW-1:0] clamp_size(input logic [sdfs_pkg::CFG_DATA_W-1:0] v);
    logic [SZW-1:0] r;
    if (v == '0) begin
      r = SZW'(1);
    end else if (32'(v) > 32'(GRID_DIM)) begin
      r = SZW'(GRID_DIM);
    end else begin
      r = SZW'(v);
    end
    return r;
  endfunction

  sdfs_pkg::bst_e state_q, state_d;
  logic init_q, init_d;
  logic [SZW-1:0] sx_q, sx_d, sy_q, sy_d, sz_q, sz_d;
  sdfs_pkg::item_t cur_q, cur_d;
  box_t bx_q, bx_d, by_q, by_d, bz_q, bz_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [TQW-1:0] t_q, t_d;
  logic [AW-1:0] addr_q, addr_d, cnt_q, cnt_d;
  logic [SQW-1:0] sq_q, sq_d;
  logic [SUMW-1:0] acc_q, acc_d;
  logic [RMW-1:0] rem_q, rem_d, r_q, r_d, bit_q, bit_d;
  logic [SCW-1:0] step_q, step_d;
  logic [TW-1:0] tot_q, tot_d;
  logic out_valid_q, out_valid_d;
  logic signed [sdfs_pkg::DIST_W-1:0] out_dist_q, out_dist_d;
  logic signed [OW-1:0] out_owner_q, out_owner_d;
  logic [MW-1:0] mem [STORE_CELLS];
  logic [MW-1:0] rdata_q;

  logic wen;
  logic [AW-1:0] waddr;
  logic [MW-1:0] wdata;
  logic signed [DW-1:0] dsel;
  logic signed [SQW-1:0] prod;
  logic [RMW:0] tst;
  logic [RMW:0] rnd;
  logic signed [VW-1:0] val;
  logic signed [sdfs_pkg::DIST_W-1:0] sat19;
  logic signed [sdfs_pkg::DIST_W-1:0] cur_dist;
  logic in_range;
  logic pop;

  assign cfg_ready_o      = 1'b1;
  assign q_pop_o          = pop;
  assign stat_o.init_busy = init_q;
  assign out_valid_o      = out_valid_q;
  assign cell_distance_o  = out_dist_q;
  assign cell_owner_o     = out_owner_q;

  always_comb begin
    case (state_q)
      sdfs_pkg::ST_SQX: dsel = $signed(DW'({i_q, 8'h00})) - $signed(DW'(cur_q.cx));
      sdfs_pkg::ST_SQY: dsel = $signed(DW'({j_q, 8'h00})) - $signed(DW'(cur_q.cy));
      default:          dsel = $signed(DW'({k_q, 8'h00})) - $signed(DW'(cur_q.cz));
    endcase
    prod = dsel * dsel;
  end

  always_comb begin
    tst      = (RMW + 1)'(r_q) + (RMW + 1)'(bit_q);
    rnd      = (rem_q > r_q) ? (RMW + 1)'(r_q) + 1'b1 : (RMW + 1)'(r_q);
    val      = $signed(VW'(rnd)) - $signed(VW'(cur_q.rad));
    if (val > $signed(VW'(sdfs_pkg::FAR_VALUE))) begin
      sat19 = sdfs_pkg::FAR_VALUE;
    end else begin
      sat19 = sdfs_pkg::DIST_W'(val);
    end
    cur_dist = $signed(rdata_q[MW-1:OW]);
    in_range = (IXW'(cur_q.idx) < IXW'(STORE_CELLS)) && (ITW'(cur_q.idx) < ITW'(tot_q));
  end

  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    sz_d        = sz_q;
    cur_d       = cur_q;
    bx_d        = bx_q;
    by_d        = by_q;
    bz_d        = bz_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    t_d         = t_q;
    addr_d      = addr_q;
    cnt_d       = cnt_q;
    sq_d        = sq_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    r_d         = r_q;
    bit_d       = bit_q;
    step_d      = step_q;
    tot_d       = tot_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_dist_d  = out_dist_q;
    out_owner_d = out_owner_q;
    wen         = 1'b0;
    waddr       = addr_q;
    wdata       = {sdfs_pkg::FAR_VALUE, sdfs_pkg::OWNER_NONE};
    pop         = 1'b0;

    if (cfg_valid_i) begin
      case (sdfs_pkg::cfg_idx_e'(cfg_index_i))
        sdfs_pkg::REG_SIZE_X: sx_d = clamp_size(cfg_data_i);
        sdfs_pkg::REG_SIZE_Y: sy_d = clamp_size(cfg_data_i);
        sdfs_pkg::REG_SIZE_Z: sz_d = clamp_size(cfg_data_i);
        default: ;
      endcase
    end

    case (state_q)
      sdfs_pkg::ST_CLEAR: begin
        wen   = 1'b1;
        waddr = cnt_q;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == AW'(STORE_CELLS - 1)) begin
          cnt_d   = '0;
          init_d  = 1'b0;
          state_d = sdfs_pkg::ST_IDLE;
        end
      end
      sdfs_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          pop   = 1'b1;
          cur_d = q_item_i;
          case (q_item_i.op)
            sdfs_pkg::OP_CLEAR: state_d = sdfs_pkg::ST_CLEAR;
            sdfs_pkg::OP_SPLAT: state_d = sdfs_pkg::ST_BOX;
            sdfs_pkg::OP_READ:  state_d = sdfs_pkg::ST_RT1;
            default:            state_d = sdfs_pkg::ST_IDLE;
          endcase
        end
      end
      sdfs_pkg::ST_BOX: begin
        bx_d = box_of(cur_q.cx, cur_q.rad, sx_q);
        by_d = box_of(cur_q.cy, cur_q.rad, sy_q);
        bz_d = box_of(cur_q.cz, cur_q.rad, sz_q);
        i_d  = bx_d.lo;
        j_d  = by_d.lo;
        k_d  = bz_d.lo;
        if (bx_d.empty || by_d.empty || bz_d.empty) begin
          state_d = sdfs_pkg::ST_IDLE;
        end else begin
          state_d = sdfs_pkg::ST_SQX;
        end
      end
      sdfs_pkg::ST_SQX: begin
        sq_d    = $unsigned(prod);
        t_d     = TQW'(TQW'(i_q) * TQW'(sy_q) + TQW'(j_q));
        state_d = sdfs_pkg::ST_SQY;
      end
      sdfs_pkg::ST_SQY: begin
        acc_d   = SUMW'(sq_q);
        sq_d    = $unsigned(prod);
        addr_d  = AW'(ADW'(t_q) * ADW'(sz_q) + ADW'(k_q));
        state_d = sdfs_pkg::ST_SQZ;
      end
      sdfs_pkg::ST_SQZ: begin
        acc_d   = acc_q + SUMW'(sq_q);
        sq_d    = $unsigned(prod);
        state_d = sdfs_pkg::ST_SUM;
      end
      sdfs_pkg::ST_SUM: begin
        rem_d   = RMW'(acc_q + SUMW'(sq_q));
        r_d     = '0;
        bit_d   = RMW'(1) << (RMW - 2);
        step_d  = '0;
        state_d = sdfs_pkg::ST_ROOT;
      end
      sdfs_pkg::ST_ROOT: begin
        if ({1'b0, rem_q} >= tst) begin
          rem_d = rem_q - tst[RMW-1:0];
          r_d   = (r_q >> 1) + bit_q;
        end else begin
          r_d   = r_q >> 1;
        end
        bit_d  = bit_q >> 2;
        step_d = step_q + 1'b1;
        if (step_q == SCW'(NSTEP - 1)) begin
          state_d = sdfs_pkg::ST_CMP;
        end
      end
      sdfs_pkg::ST_CMP: begin
        if (sat19 < cur_dist) begin
          wen   = 1'b1;
          waddr = addr_q;
          wdata = {sat19, cur_q.id};
        end
        state_d = sdfs_pkg::ST_SQX;
        if (k_q != bz_q.hi) begin
          k_d = k_q + 1'b1;
        end else begin
          k_d = bz_q.lo;
          if (j_q != by_q.hi) begin
            j_d = j_q + 1'b1;
          end else begin
            j_d = by_q.lo;
            if (i_q != bx_q.hi) begin
              i_d = i_q + 1'b1;
            end else begin
              state_d = sdfs_pkg::ST_IDLE;
            end
          end
        end
      end
      sdfs_pkg::ST_RT1: begin
        tot_d   = TW'(TW'(sx_q) * TW'(sy_q));
        addr_d  = AW'(cur_q.idx);
        state_d = sdfs_pkg::ST_RT2;
      end
      sdfs_pkg::ST_RT2: begin
        tot_d   = TW'(tot_q * TW'(sz_q));
        state_d = sdfs_pkg::ST_ROUT;
      end
      sdfs_pkg::ST_ROUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_dist_d  = in_range ? $signed(rdata_q[MW-1:OW]) : sdfs_pkg::FAR_VALUE;
          out_owner_d = in_range ? $signed(rdata_q[OW-1:0]) : sdfs_pkg::OWNER_NONE;
          state_d     = sdfs_pkg::ST_IDLE;
        end
      end
      default: state_d = sdfs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sdfs_pkg::ST_CLEAR;
      init_q      <= 1'b1;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      sx_q        <= SZW'(SIZE_RST);
      sy_q        <= SZW'(SIZE_RST);
      sz_q        <= SZW'(SIZE_RST);
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      sx_q        <= sx_d;
      sy_q        <= sy_d;
      sz_q        <= sz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    bx_q        <= bx_d;
    by_q        <= by_d;
    bz_q        <= bz_d;
    i_q         <= i_d;
    j_q         <= j_d;
    k_q         <= k_d;
    t_q         <= t_d;
    addr_q      <= addr_d;
    sq_q        <= sq_d;
    acc_q       <= acc_d;
    rem_q       <= rem_d;
    r_q         <= r_d;
    bit_q       <= bit_d;
    step_q      <= step_d;
    tot_q       <= tot_d;
    out_dist_q  <= out_dist_d;
    out_owner_q <= out_owner_d;
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[addr_q];
  end

`ifndef NO_ASSERTIONS
  a_wen_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wen |-> (state_q == sdfs_pkg::ST_CLEAR || state_q == sdfs_pkg::ST_CMP))
    else $error("store written outside a sweep or compare");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (state_q == sdfs_pkg::ST_IDLE && !init_q))
    else $error("queue popped while engine busy");
  a_cmp_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sdfs_pkg::ST_CMP) |-> (k_q >= bz_q.lo && k_q <= bz_q.hi && j_q <= by_q.hi
                                       && i_q <= bx_q.hi))
    else $error("cell walk left the box");
  a_cmp_after_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sdfs_pkg::ST_CMP) |-> ($past(state_q) == sdfs_pkg::ST_ROOT))
    else $error("compare without a finished root");
`endif

endmodule

// ===== design/sphere_distance_field_splat_top.sv =====
// Top level: front end, item queue and engine of the sphere distance field splat block.
// A read passes through ST_RT1, ST_RT2 and ST_ROUT to its registered result beat; clear
// and splat give none. A splat takes each visited cell through ST_SQX, ST_SQY, ST_SQZ, ST_SUM,
// NSTEP root steps (NSTEP = 16 at the default grid) and ST_CMP, bound by the
// one-bit-pair-per-cycle square root. A clear writes all GRID_DIM^3 cells (262144 by default);
// so does the pass after reset, taking no input beat; configuration beats are taken at any time.
module sphere_distance_field_splat_top #(
  parameter int GRID_DIM     = sdfs_pkg::GRID_DIM_DEFAULT,
  parameter int MARGIN_CELLS = sdfs_pkg::MARGIN_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [sdfs_pkg::OP_W-1:0]           opcode_i,
  input  logic [sdfs_pkg::CENTER_W-1:0]       center_x_i,
  input  logic [sdfs_pkg::CENTER_W-1:0]       center_y_i,
  input  logic [sdfs_pkg::CENTER_W-1:0]       center_z_i,
  input  logic [sdfs_pkg::RADIUS_W-1:0]       sphere_radius_i,
  input  logic signed [sdfs_pkg::ID_W-1:0]    sphere_id_i,
  input  logic [sdfs_pkg::IDX_W-1:0]          cell_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [sdfs_pkg::DIST_W-1:0]  cell_distance_o,
  output logic signed [sdfs_pkg::OWNER_W-1:0] cell_owner_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sdfs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sdfs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  sdfs_pkg::stat_t stat;
  sdfs_pkg::item_t push_item;
  sdfs_pkg::item_t head_item;
  logic push;
  logic full;
  logic pop;
  logic head_valid;

  sdfs_front u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .center_x_i      (center_x_i),
    .center_y_i      (center_y_i),
    .center_z_i      (center_z_i),
    .sphere_radius_i (sphere_radius_i),
    .sphere_id_i     (sphere_id_i),
    .cell_index_i    (cell_index_i),
    .stat_i          (stat),
    .full_i          (full),
    .push_o          (push),
    .item_o          (push_item)
  );

  sdfs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  sdfs_back #(
    .GRID_DIM     (GRID_DIM),
    .MARGIN_CELLS (MARGIN_CELLS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .q_valid_i       (head_valid),
    .q_item_i        (head_item),
    .q_pop_o         (pop),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cell_distance_o (cell_distance_o),
    .cell_owner_o    (cell_owner_o)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench of the sphere distance field splat block: checks read beats against a local grid model.
`timescale 1ns / 1ps

module testbench;

  localparam int NCELLS = sdfs_pkg::GRID_DIM_DEFAULT * sdfs_pkg::GRID_DIM_DEFAULT *
                          sdfs_pkg::GRID_DIM_DEFAULT;

  typedef struct {
    logic signed [sdfs_pkg::DIST_W-1:0]  dval;
    logic signed [sdfs_pkg::OWNER_W-1:0] owner;
  } cell_t;

  class sdf_board;
    int                  dist_grid [NCELLS];
    shortint             owner_grid [NCELLS];
    int unsigned         nx, ny, nz;
    cell_t               reads_due [$];
    int                  errors;

    function new();
      nx = 64; ny = 64; nz = 64;
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      for (int n = 0; n < NCELLS; n++) begin
        dist_grid[n]  = 262143;
        owner_grid[n] = -1;
      end
    endfunction

    function int unsigned sat_size(logic [sdfs_pkg::CFG_DATA_W-1:0] v);
      if (v < 1) return 1;
      if (v > sdfs_pkg::GRID_DIM_DEFAULT) return sdfs_pkg::GRID_DIM_DEFAULT;
      return v;
    endfunction

    function void note_config(sdfs_pkg::cfg_idx_e idx, logic [sdfs_pkg::CFG_DATA_W-1:0] v);
      case (idx)
        sdfs_pkg::REG_SIZE_X: nx = sat_size(v);
        sdfs_pkg::REG_SIZE_Y: ny = sat_size(v);
        sdfs_pkg::REG_SIZE_Z: nz = sat_size(v);
        default: ;
      endcase
    endfunction

    function longint unsigned root_near(longint unsigned v);
      longint unsigned r, b, rem;
      r = 0; b = 64'd1 << 62; rem = v;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
        if (rem >= r + b) begin
          rem = rem - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      if (rem > r) r++;
      return r;
    endfunction

    function longint lo_cell(longint q);
      if (q >= 0) return q / 256;
      return -((-q + 255) / 256);
    endfunction

    function longint hi_cell(longint q);
      if (q >= 0) return (q + 255) / 256;
      return -((-q) / 256);
    endfunction

    function void splat(longint cx, longint cy, longint cz, longint rad, shortint id);
      longint reach, lx, hx, ly, hy, lz, hz, dx, dy, dz, val, idx;
      reach = rad + sdfs_pkg::MARGIN_DEFAULT * 256;
      lx = lo_cell(cx - reach); if (lx < 0) lx = 0;
      ly = lo_cell(cy - reach); if (ly < 0) ly = 0;
      lz = lo_cell(cz - reach); if (lz < 0) lz = 0;
      hx = hi_cell(cx + reach); if (hx > nx - 1) hx = nx - 1;
      hy = hi_cell(cy + reach); if (hy > ny - 1) hy = ny - 1;
      hz = hi_cell(cz + reach); if (hz > nz - 1) hz = nz - 1;
      for (longint i = lx; i <= hx; i++) begin
        dx = i * 256 - cx;
        for (longint j = ly; j <= hy; j++) begin
          dy = j * 256 - cy;
          for (longint k = lz; k <= hz; k++) begin
            dz = k * 256 - cz;
            val = longint'(root_near(dx * dx + dy * dy + dz * dz)) - rad;
            if (val > 262143) val = 262143;
            idx = (i * ny + j) * nz + k;
            if (idx >= 0 && idx < NCELLS && val < dist_grid[idx]) begin
              dist_grid[idx]  = int'(val);
              owner_grid[idx] = id;
            end
          end
        end
      end
    endfunction

    function void note_input(sdfs_pkg::item_t it);
      cell_t c;
      case (it.op)
        sdfs_pkg::OP_CLEAR: wipe();
        sdfs_pkg::OP_SPLAT: splat(it.cx, it.cy, it.cz, it.rad, it.id);
        sdfs_pkg::OP_READ: begin
          c.dval  = sdfs_pkg::FAR_VALUE;
          c.owner = sdfs_pkg::OWNER_NONE;
          if (it.idx < longint'(nx) * ny * nz) begin
            c.dval  = dist_grid[it.idx];
            c.owner = owner_grid[it.idx];
          end
          reads_due.insert(reads_due.size(), c);
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic signed [sdfs_pkg::DIST_W-1:0] d,
                      logic signed [sdfs_pkg::OWNER_W-1:0] o);
      cell_t c;
      if (reads_due.size() == 0) begin
        report($sformatf("unexpected beat dist=%0d owner=%0d", d, o));
      end else begin
        c = reads_due.pop_front();
        if (d !== c.dval)
          report($sformatf("cell_distance got %0d want %0d", d, c.dval));
        if (o !== c.owner)
          report($sformatf("cell_owner got %0d want %0d", o, c.owner));
      end
    endtask
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o;
  logic [sdfs_pkg::OP_W-1:0] opcode_i;
  logic [sdfs_pkg::CENTER_W-1:0] center_x_i, center_y_i, center_z_i;
  logic [sdfs_pkg::RADIUS_W-1:0] sphere_radius_i;
  logic signed [sdfs_pkg::ID_W-1:0] sphere_id_i;
  logic [sdfs_pkg::IDX_W-1:0] cell_index_i;
  logic out_valid_o, out_ready_i;
  logic signed [sdfs_pkg::DIST_W-1:0] cell_distance_o;
  logic signed [sdfs_pkg::OWNER_W-1:0] cell_owner_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [sdfs_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [sdfs_pkg::CFG_DATA_W-1:0] cfg_data_i;

  sdf_board board;
  bit idle_on = 1;
  int hold_ask = 0;

  sphere_distance_field_splat_top u_top (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int burst, hold, seen;
    burst = 0; hold = 0; seen = 0;
    out_ready_i = 0;
    forever begin
      @(negedge clk_i);
      if (hold_ask != seen) begin
        seen = hold_ask;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i = 0;
      end else if (burst > 0) begin
        burst--;
        out_ready_i = 0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(0, 3);
        out_ready_i = 0;
      end else begin
        out_ready_i = 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result(cell_distance_o, cell_owner_o);
  end

  task send_item(sdfs_pkg::item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i = 1;
    opcode_i = it.op; center_x_i = it.cx; center_y_i = it.cy; center_z_i = it.cz;
    sphere_radius_i = it.rad; sphere_id_i = it.id; cell_index_i = it.idx;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_input(it);
    @(negedge clk_i);
    in_valid_i = 0;
  endtask

  task write_reg(sdfs_pkg::cfg_idx_e idx, logic [sdfs_pkg::CFG_DATA_W-1:0] v);
    cfg_valid_i = 1; cfg_index_i = idx; cfg_data_i = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.note_config(idx, v);
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  function sdfs_pkg::item_t make_item(sdfs_pkg::op_e op, int cx, int cy, int cz, int rad,
                                      int id, int idx);
    sdfs_pkg::item_t it;
    it.op  = op;
    it.cx  = sdfs_pkg::CENTER_W'(cx);
    it.cy  = sdfs_pkg::CENTER_W'(cy);
    it.cz  = sdfs_pkg::CENTER_W'(cz);
    it.rad = sdfs_pkg::RADIUS_W'(rad);
    it.id  = sdfs_pkg::ID_W'(id);
    it.idx = sdfs_pkg::IDX_W'(idx);
    return it;
  endfunction

  // A read is answered only after every earlier item is done, so its beat marks idle.
  task drain();
    send_item(make_item(sdfs_pkg::OP_READ, 0, 0, 0, 0, 0, $urandom_range(0, 63)));
    while (board.reads_due.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task set_sizes(int x, int y, int z);
    write_reg(sdfs_pkg::REG_SIZE_X, sdfs_pkg::CFG_DATA_W'(x));
    write_reg(sdfs_pkg::REG_SIZE_Y, sdfs_pkg::CFG_DATA_W'(y));
    write_reg(sdfs_pkg::REG_SIZE_Z, sdfs_pkg::CFG_DATA_W'(z));
  endtask

  function sdfs_pkg::item_t rand_item(int unsigned total);
    sdfs_pkg::item_t it;
    int sel, span;
    it = make_item(sdfs_pkg::OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom);
    sel = $urandom_range(0, 99);
    span = board.nx > board.ny ? board.nx : board.ny;
    if (board.nz > span) span = board.nz;
    if (sel < 40) begin
      it.op = sdfs_pkg::OP_SPLAT;
      if ($urandom_range(0, 4) != 0) begin
        it.cx  = sdfs_pkg::CENTER_W'($urandom_range(0, span * 256 + 512));
        it.cy  = sdfs_pkg::CENTER_W'($urandom_range(0, span * 256 + 512));
        it.cz  = sdfs_pkg::CENTER_W'($urandom_range(0, span * 256 + 512));
        it.rad = sdfs_pkg::RADIUS_W'($urandom_range(0, 1023));
      end
    end else if (sel < 95) begin
      if ($urandom_range(0, 4) != 0) it.idx = sdfs_pkg::IDX_W'($urandom_range(0, total - 1));
    end else begin
      it.op = sdfs_pkg::op_e'(2'd3);
    end
    return it;
  endfunction

  initial begin
    int sx, sy, sz;
    board = new();
    rst_ni = 0;
    in_valid_i = 0; opcode_i = sdfs_pkg::OP_CLEAR;
    center_x_i = 0; center_y_i = 0; center_z_i = 0;
    sphere_radius_i = 0; sphere_id_i = 0; cell_index_i = 0;
    cfg_valid_i = 0; cfg_index_i = sdfs_pkg::REG_SIZE_X; cfg_data_i = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1;

    send_item(make_item(sdfs_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
    send_item(make_item(sdfs_pkg::OP_READ, 0, 0, 0, 0, 0, 262143));
    send_item(make_item(sdfs_pkg::OP_SPLAT, 16383, 16383, 16383, 0, 32767, 0));
    send_item(make_item(sdfs_pkg::OP_SPLAT, 0, 0, 0, 0, -1, 0));
    send_item(make_item(sdfs_pkg::OP_SPLAT, 2000, 2100, 1900, 300, -32768, 0));
    send_item(make_item(sdfs_pkg::OP_READ, 0, 0, 0, 0, 0, 262143));
    send_item(make_item(sdfs_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
    send_item(make_item(sdfs_pkg::OP_READ, 0, 0, 0, 0, 0, (8 * 64 + 8) * 64 + 7));
    send_item(make_item(sdfs_pkg::op_e'(2'd3), 16383, 16383, 16383, 4095, -1, 262143));
    drain();

    set_sizes(8, 0, 127);
    send_item(make_item(sdfs_pkg::OP_SPLAT, 1000, 200, 3000, 4095, 7, 0));
    send_item(make_item(sdfs_pkg::OP_SPLAT, 16383, 16383, 16383, 100, 9, 0));
    send_item(make_item(sdfs_pkg::OP_READ, 0, 0, 0, 0, 0, 8 * 64 - 1));
    send_item(make_item(sdfs_pkg::OP_READ, 0, 0, 0, 0, 0, 8 * 64));
    hold_ask++;
    for (int n = 0; n < 8; n++)
      send_item(make_item(sdfs_pkg::OP_READ, 0, 0, 0, 0, 0, $urandom_range(0, 511)));
    drain();
    send_item(make_item(sdfs_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0));
    send_item(make_item(sdfs_pkg::OP_READ, 0, 0, 0, 0, 0, 5));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      sx = $urandom_range(1, 8); sy = $urandom_range(1, 8); sz = $urandom_range(1, 8);
      if (ph == 2) sx = 127;
      if (ph == 3) sy = 1;
      if (ph == 5) idle_on = 0;
      set_sizes(sx, sy, sz);
      for (int n = 0; n < 18; n++)
        send_item(rand_item(board.nx * board.ny * board.nz));
      if (ph == 3) send_item(make_item(sdfs_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0));
      drain();
    end

    if (board.reads_due.size() != 0) board.report("results left over");
    if (board.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
